FILE: rtl/pcc_pkg.sv
// Package: shared types, register indexes and the microcode table for the PID controller.
package pcc_pkg;

  localparam int STEP_W = 3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_SAMPLE_PER  = 3'd3;
  localparam logic [2:0] REG_INV_PER     = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [2:0] REG_DRIVE_LIMIT = 3'd6;

  // Multiplier operand A selects (33-bit signed).
  localparam logic [1:0] A_ERR   = 2'd0;
  localparam logic [1:0] A_DIFF  = 2'd1;
  localparam logic [1:0] A_INTEG = 2'd2;
  localparam logic [1:0] A_DERIV = 2'd3;

  // Multiplier operand B selects (32-bit signed).
  localparam logic [2:0] B_DT  = 3'd0;
  localparam logic [2:0] B_INV = 3'd1;
  localparam logic [2:0] B_KP  = 3'd2;
  localparam logic [2:0] B_KI  = 3'd3;
  localparam logic [2:0] B_KD  = 3'd4;

  // Write-back operations.
  localparam logic [2:0] WB_NONE  = 3'd0;
  localparam logic [2:0] WB_ERR   = 3'd1;
  localparam logic [2:0] WB_INTEG = 3'd2;
  localparam logic [2:0] WB_DERIV = 3'd3;
  localparam logic [2:0] WB_LOAD  = 3'd4;
  localparam logic [2:0] WB_ADD   = 3'd5;
  localparam logic [2:0] WB_OUT   = 3'd6;

  // Jump conditions.
  localparam logic [1:0] COND_NEVER    = 2'd0;
  localparam logic [1:0] COND_NO_IN    = 2'd1;
  localparam logic [1:0] COND_OUT_BUSY = 2'd2;
  localparam logic [1:0] COND_ALWAYS   = 2'd3;

  typedef struct packed {
    logic              in_rdy;
    logic [1:0]        a_sel;
    logic [2:0]        b_sel;
    logic [2:0]        wb;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } status_t;

  // Control store. Steps 1-6 each issue a product; steps 2-6 retire the one issued before.
  function automatic ctl_t pcc_ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    unique case (step)
      3'd0: begin
        w.in_rdy = 1'b1;
        w.wb     = WB_ERR;
        w.cond   = COND_NO_IN;
        w.target = 3'd0;
      end
      3'd1: begin
        w.a_sel = A_ERR;
        w.b_sel = B_DT;
      end
      3'd2: begin
        w.a_sel = A_DIFF;
        w.b_sel = B_INV;
        w.wb    = WB_INTEG;
      end
      3'd3: begin
        w.a_sel = A_ERR;
        w.b_sel = B_KP;
        w.wb    = WB_DERIV;
      end
      3'd4: begin
        w.a_sel = A_INTEG;
        w.b_sel = B_KI;
        w.wb    = WB_LOAD;
      end
      3'd5: begin
        w.a_sel = A_DERIV;
        w.b_sel = B_KD;
        w.wb    = WB_ADD;
      end
      3'd6: begin
        // The derivative product is issued again, so it stays put while this step waits.
        w.a_sel  = A_DERIV;
        w.b_sel  = B_KD;
        w.wb     = WB_OUT;
        w.cond   = COND_OUT_BUSY;
        w.target = 3'd6;
        w.last   = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = 3'd0;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/pcc_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module pcc_sequencer
  import pcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctl_t    ctl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              jump;

  assign ctl = pcc_ucode(step);

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_IN:    jump = !status.in_valid;
      COND_OUT_BUSY: jump = status.out_busy;
      COND_ALWAYS:   jump = 1'b1;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    priority if (jump) begin
      step_next = ctl.target;
    end else if (ctl.last) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (step == 3'd0 && !status.in_valid) |=> step == 3'd0)
    else $error("sequencer left the wait step without an input transfer");

  a_start_advances: assert property (@(posedge clk) disable iff (rst)
    (step == 3'd0 && status.in_valid) |=> step == 3'd1)
    else $error("sequencer did not start the program after an input transfer");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.wb == WB_OUT && status.out_busy) |=> ctl.wb == WB_OUT)
    else $error("sequencer left the output step while the result register was full");

endmodule

FILE: rtl/pcc_datapath.sv
// Datapath: shared multiplier, error, integral, derivative, sum and result register.
module pcc_datapath
  import pcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic               in_valid,
  input  logic signed [31:0] measured,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] prop_gain,
  input  logic signed [31:0] integ_gain,
  input  logic signed [31:0] deriv_gain,
  input  logic        [30:0] sample_period,
  input  logic        [30:0] inv_sample_period,
  input  logic        [30:0] integ_limit,
  input  logic        [30:0] drive_limit,
  output logic               out_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive
);

  logic signed [31:0] err;
  logic signed [31:0] last_err;
  logic signed [31:0] integ;
  logic signed [31:0] deriv;
  logic signed [48:0] prod;
  logic signed [49:0] acc;

  logic signed [32:0] err_raw;
  logic signed [31:0] err_sat;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_full;
  logic signed [49:0] integ_sum;
  logic signed [49:0] ilim;
  logic signed [31:0] integ_clamped;
  logic signed [31:0] deriv_sat;
  logic signed [49:0] total;
  logic signed [49:0] dlim;
  logic signed [31:0] drive_clamped;

  assign out_busy = out_valid && !out_ready;

  // Error at 33 bits, saturated back to 32.
  assign err_raw = {setpoint[31], setpoint} - {measured[31], measured};
  always_comb begin
    if (err_raw[32] != err_raw[31]) begin
      err_sat = err_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = err_raw[31:0];
    end
  end

  always_comb begin
    unique case (ctl.a_sel)
      A_ERR:   mul_a = {err[31], err};
      A_DIFF:  mul_a = {err[31], err} - {last_err[31], last_err};
      A_INTEG: mul_a = {integ[31], integ};
      A_DERIV: mul_a = {deriv[31], deriv};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.b_sel)
      B_DT:    mul_b = {1'b0, sample_period};
      B_INV:   mul_b = {1'b0, inv_sample_period};
      B_KP:    mul_b = prop_gain;
      B_KI:    mul_b = integ_gain;
      B_KD:    mul_b = deriv_gain;
      default: mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Integral update with symmetric clamp.
  assign integ_sum = {{18{integ[31]}}, integ} + {prod[48], prod};
  assign ilim      = {19'b0, integ_limit};
  always_comb begin
    priority if (integ_sum > ilim) begin
      integ_clamped = ilim[31:0];
    end else if (integ_sum < -ilim) begin
      integ_clamped = -ilim[31:0];
    end else begin
      integ_clamped = integ_sum[31:0];
    end
  end

  always_comb begin
    priority if (prod > 49'sh0_7FFF_FFFF) begin
      deriv_sat = 32'sh7FFF_FFFF;
    end else if (prod < -49'sh0_8000_0000) begin
      deriv_sat = 32'sh8000_0000;
    end else begin
      deriv_sat = prod[31:0];
    end
  end

  // Final sum with the drive clamp.
  assign total = acc + {prod[48], prod};
  assign dlim  = {19'b0, drive_limit};
  always_comb begin
    priority if (total > dlim) begin
      drive_clamped = dlim[31:0];
    end else if (total < -dlim) begin
      drive_clamped = -dlim[31:0];
    end else begin
      drive_clamped = total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[64:16];
    if (rst) begin
      integ    <= '0;
      last_err <= '0;
    end else begin
      unique case (ctl.wb)
        WB_ERR: begin
          if (in_valid) begin
            err <= err_sat;
          end
        end
        WB_INTEG: begin
          integ    <= integ_clamped;
          last_err <= err;
        end
        WB_DERIV: deriv <= deriv_sat;
        WB_LOAD:  acc <= {prod[48], prod};
        WB_ADD:   acc <= total;
        WB_OUT: begin
          if (!out_busy) begin
            drive <= drive_clamped;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.wb == WB_OUT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (ctl.wb == WB_INTEG) |=>
      ($signed({integ[31], integ}) <= $signed({2'b0, $past(integ_limit)})
       && $signed({integ[31], integ}) >= -$signed({2'b0, $past(integ_limit)})))
    else $error("integral left its clamp range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (ctl.wb == WB_OUT && !out_busy) |=> out_valid)
    else $error("result register not marked full after the output step");

endmodule

FILE: rtl/pid_controller_clamped_unit.sv
// Top level: PID controller with integral clamp and saturated drive, Q16.16.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata[31:0] measured, [63:32] setpoint
//   m_*       out        m_tvalid/m_tready   m_tdata[31:0] drive
//   cfg_*     in         cfg_wr_en           cfg_addr register index, cfg_wdata value
//
// From the input transfer to the result register, the microcode program issues five
// products through one shared 33x32 multiplier, one per step. The program is seven
// steps long and takes no new sample until it is through with the last one. A new
// sample is taken as soon as the program returns to its wait step, even while the
// previous result still waits on m_*.
// Reset (rst, synchronous) restores the register defaults and clears the integral and
// the stored error; s_tready stays low while rst is high. A stalled output only holds
// the program at its last step when a fresh result is ready and the result register is
// still full.
module pid_controller_clamped_unit
  import pcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured, [63:32] setpoint
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] drive
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers.
  logic signed [31:0] prop_gain;
  logic signed [31:0] integ_gain;
  logic signed [31:0] deriv_gain;
  logic        [30:0] sample_period;
  logic        [30:0] inv_sample_period;
  logic        [30:0] integ_limit;
  logic        [30:0] drive_limit;

  ctl_t               ctl;
  status_t            status;
  logic               out_busy;
  logic signed [31:0] drive;

  // Writes to an index past the last register fall through and change nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain         <= 32'sd65536;
      integ_gain        <= 32'sd6554;
      deriv_gain        <= 32'sd32768;
      sample_period     <= 31'd6554;
      inv_sample_period <= 31'd655360;
      integ_limit       <= 31'd65536;
      drive_limit       <= 31'd655360;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PROP_GAIN:   prop_gain         <= cfg_wdata;
        REG_INTEG_GAIN:  integ_gain        <= cfg_wdata;
        REG_DERIV_GAIN:  deriv_gain        <= cfg_wdata;
        REG_SAMPLE_PER:  sample_period     <= cfg_wdata[30:0];
        REG_INV_PER:     inv_sample_period <= cfg_wdata[30:0];
        REG_INTEG_LIMIT: integ_limit       <= cfg_wdata[30:0];
        REG_DRIVE_LIMIT: drive_limit       <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // The input side is open only while the program sits in its wait step and out of reset.
  assign s_tready        = ctl.in_rdy && !rst;
  assign status.in_valid = s_tvalid;
  assign status.out_busy = out_busy;

  pcc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  pcc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .in_valid          (s_tvalid),
    .measured          (s_tdata[31:0]),
    .setpoint          (s_tdata[63:32]),
    .prop_gain         (prop_gain),
    .integ_gain        (integ_gain),
    .deriv_gain        (deriv_gain),
    .sample_period     (sample_period),
    .inv_sample_period (inv_sample_period),
    .integ_limit       (integ_limit),
    .drive_limit       (drive_limit),
    .out_busy          (out_busy),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .drive             (drive)
  );

  assign m_tdata = drive;

  // A transfer starts the program, so the input side closes on the next cycle.
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted a second sample while one was in progress");

  // A fresh result always lies inside the drive clamp.
  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |->
      ($signed({m_tdata[31], m_tdata}) <= $signed({2'b0, drive_limit})
       && $signed({m_tdata[31], m_tdata}) >= -$signed({2'b0, drive_limit})))
    else $error("drive outside its clamp range");

endmodule

FILE: tb/pid_controller_clamped_unit_test.sv
// Self-checking stream testbench for the clamped PID controller unit.
`timescale 1ns / 1ps

module pid_controller_clamped_unit_test;
  import pcc_pkg::*;

  // The register map ends at REG_DRIVE_LIMIT; the next index selects nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // The slowest legal run spends the longest sender gap, the microcode program and the
  // longest receiver stall on each of about 1800 samples. The limit below is several
  // times that.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [31:0] measured, [63:32] setpoint
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] drive
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // Shadow copy of the configuration and of the loop state, kept by the predictor.
  longint kp_shadow, ki_shadow, kd_shadow;
  longint dt_shadow, inv_dt_shadow, integ_limit_shadow, drive_limit_shadow;
  longint integ_shadow, prev_err_shadow;

  logic [31:0] drive_queue[$];
  logic [31:0] drive_want;
  int          mismatch_count;
  int          cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_request;

  pid_controller_clamped_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in 64-bit signed integers, which hold every
  // Q16.16 product exactly; an arithmetic shift by 16 then floors the product.
  // ---------------------------------------------------------------------------
  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic reset_shadow();
    kp_shadow          = 65536;
    ki_shadow          = 6554;
    kd_shadow          = 32768;
    dt_shadow          = 6554;
    inv_dt_shadow      = 655360;
    integ_limit_shadow = 65536;
    drive_limit_shadow = 655360;
    integ_shadow       = 0;
    prev_err_shadow    = 0;
  endtask

  // Advances the shadow loop state by one sample and returns the drive it yields.
  function automatic logic [31:0] predict_drive(input logic [31:0] meas,
                                                input logic [31:0] setp);
    longint err, deriv, total;
    err = sat32(longint'($signed(setp)) - longint'($signed(meas)));
    integ_shadow = clamp_sym(integ_shadow + ((err * dt_shadow) >>> 16), integ_limit_shadow);
    // The error difference is kept at full 33-bit width before the multiply.
    deriv = sat32(((err - prev_err_shadow) * inv_dt_shadow) >>> 16);
    prev_err_shadow = err;
    total = ((kp_shadow * err) >>> 16) + ((ki_shadow * integ_shadow) >>> 16)
          + ((kd_shadow * deriv) >>> 16);
    total = clamp_sym(total, drive_limit_shadow);
    return total[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly short, sometimes medium, rarely long.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (!tx_idle_on || $urandom_range(0, 1) == 0) return 0;
    return gap_len();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at a falling edge. The valid is left
  // high when no gap follows, so back-to-back samples never lower and raise it in
  // the same step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [31:0] meas, input logic [31:0] setp);
    int gap;
    s_tdata  <= {setp, meas};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // The transfer happened at this edge, so the prediction uses the state as of now.
    drive_queue.push_back(predict_drive(meas, setp));
    @(negedge clk);
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering samples and waits until every predicted drive has been seen.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (drive_queue.size() != 0) @(negedge clk);
  endtask

  // Register writes only ever happen with the unit drained.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    drain();
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    // Gains are sign-extended; the period and limit registers keep their low 31 bits.
    case (idx)
      REG_PROP_GAIN:   kp_shadow          = longint'($signed(val));
      REG_INTEG_GAIN:  ki_shadow          = longint'($signed(val));
      REG_DERIV_GAIN:  kd_shadow          = longint'($signed(val));
      REG_SAMPLE_PER:  dt_shadow          = longint'(val[30:0]);
      REG_INV_PER:     inv_dt_shadow      = longint'(val[30:0]);
      REG_INTEG_LIMIT: integ_limit_shadow = longint'(val[30:0]);
      REG_DRIVE_LIMIT: drive_limit_shadow = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Reset values, zero input, and both directions of error saturation. Sweeping
  // from one extreme to the other also saturates the derivative.
  task automatic test_reset_defaults();
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0001_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Largest gains of both signs with wide-open limits and periods. The all-ones
  // writes to the 31-bit registers check that bit 31 is dropped.
  task automatic test_extreme_gains();
    write_reg(REG_PROP_GAIN,   32'h7FFF_FFFF);
    write_reg(REG_INTEG_GAIN,  32'h8000_0000);
    write_reg(REG_DERIV_GAIN,  32'h7FFF_FFFF);
    write_reg(REG_SAMPLE_PER,  32'hFFFF_FFFF);
    write_reg(REG_INV_PER,     32'hFFFF_FFFF);
    write_reg(REG_INTEG_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_DRIVE_LIMIT, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    write_reg(REG_PROP_GAIN, 32'h8000_0000);
    send_sample(32'h1234_5678, 32'hFEDC_BA98);
  endtask

  // A zero limit pins the integral and the drive to zero.
  task automatic test_zero_limits();
    write_reg(REG_INTEG_LIMIT, 32'h0000_0000);
    write_reg(REG_DRIVE_LIMIT, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h4000_0000);
    send_sample(32'hC000_0000, 32'h0000_0000);
    write_reg(REG_DRIVE_LIMIT, 32'h7FFF_FFFF);
    send_sample(32'h0001_0000, 32'h0003_0000);
  endtask

  // A zero period holds the integral; a zero reciprocal removes the derivative.
  task automatic test_zero_periods();
    write_reg(REG_INTEG_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_SAMPLE_PER,  32'h0000_0000);
    write_reg(REG_INV_PER,     32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0010_0000);
    send_sample(32'h0010_0000, 32'h0000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // Wind the integral up under a wide clamp, then lower the clamp; the next sample
  // must pull the stored integral back inside.
  task automatic test_limit_lowered();
    write_reg(REG_PROP_GAIN,   32'h0001_0000);
    write_reg(REG_INTEG_GAIN,  32'h0001_0000);
    write_reg(REG_DERIV_GAIN,  32'h0000_0000);
    write_reg(REG_SAMPLE_PER,  32'h0008_0000);
    write_reg(REG_INV_PER,     32'h000A_0000);
    write_reg(REG_INTEG_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_DRIVE_LIMIT, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h0064_0000);
    send_sample(32'h0000_0000, 32'h0064_0000);
    send_sample(32'h0000_0000, 32'h0064_0000);
    write_reg(REG_INTEG_LIMIT, 32'h0001_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    write_reg(REG_SAMPLE_PER, 32'h0000_0000);
    write_reg(REG_INTEG_LIMIT, 32'h0000_8000);
    send_sample(32'h0000_0000, 32'h0000_0000);
  endtask

  // A write past the last register must leave every setting as it was.
  task automatic test_unknown_register();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(32'h0002_0000, 32'h0005_0000);
    write_reg(REG_UNUSED, 32'h0000_0000);
    send_sample(32'hFFFE_0000, 32'h0001_8000);
  endtask

  // ---------------------------------------------------------------------------
  // Random operation.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_reg_value(input int idx);
    bit is_gain;
    int r;
    is_gain = (idx <= REG_DERIV_GAIN);
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) begin
      if (!is_gain) return 32'hFFFF_FFFF;
      return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    if (r <= 3) return $urandom;
    // Moderate settings keep the loop out of saturation most of the time.
    if (is_gain) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    return $urandom_range(0, 32'h0010_0000);
  endfunction

  task automatic randomize_config();
    for (int idx = REG_PROP_GAIN; idx <= REG_DRIVE_LIMIT; idx++) begin
      write_reg(3'(idx), pick_reg_value(idx));
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  // Most samples follow a process value wandering near a setpoint, so the integral
  // and derivative paths see realistic, unsaturated values; the rest are raw words.
  task automatic test_random_operation(input int phases, input int per_phase);
    int base;
    int meas;
    int setp;
    for (int p = 0; p < phases; p++) begin
      randomize_config();
      tx_idle_on = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle_on = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      if (p == phases - 1) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      base = $urandom_range(0, 32'h7FFF_FFFF);
      base = base - 32'h4000_0000;
      setp = base + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      meas = base;
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 35) begin
          send_sample($urandom, $urandom);
        end else begin
          if ($urandom_range(0, 19) == 0) setp = base + $urandom_range(0, 32'h0008_0000)
                                                 - 32'h0004_0000;
          meas = base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          send_sample(meas, setp);
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while samples are offered without gaps;
  // the result register fills, the program holds at its last step and s_tready drops.
  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    randomize_config();
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_sample($urandom, $urandom);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver drives m_tready at falling edges, and the checker
  // compares each transfer against the oldest predicted drive at rising edges.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
        stall_left = gap_len() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_queue.size() == 0) begin
        report_mismatch($sformatf("drive %h with no sample outstanding", m_tdata));
      end else begin
        drive_want = drive_queue.pop_front();
        if (m_tdata !== drive_want) begin
          report_mismatch($sformatf("drive %h, predicted %h", m_tdata, drive_want));
        end
      end
    end
  end

  // A hang anywhere ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_wr_en      = 1'b0;
    cfg_addr       = REG_PROP_GAIN;
    cfg_wdata      = '0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    hold_request   = 1'b0;
    mismatch_count = 0;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_extreme_gains();
    test_zero_limits();
    test_zero_periods();
    test_limit_lowered();
    test_unknown_register();
    test_random_operation(7, 250);
    test_back_pressure();

    // Everything predicted has arrived; keep the clock running so that any stray transfer
    // shows before deciding.
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
